// File: design/qf3_pkg.sv
`timescale 1ns / 1ps

package qf3_pkg;

   localparam int unsigned X_W     = 15;
   localparam int unsigned Y_W     = 16;
   localparam int unsigned VAL_W   = 64;
   localparam int unsigned T_W     = 48;
   localparam int unsigned OPB_W   = 18;
   localparam int unsigned DIFF_W  = 17;
   localparam int unsigned DMAG_W  = 46;
   localparam int unsigned REM_W   = 48;
   localparam int unsigned CNT_W   = 7;
   localparam int unsigned PC_W    = 5;
   localparam int unsigned NUM_UOPS = 20;
   localparam int unsigned FRAC_BASE = 24;
   localparam int unsigned FRAC_STEP = 8;

   // Operand A of the shared multiplier.
   typedef enum logic [2:0] {
      OPA_T   = 3'd0,
      OPA_XA  = 3'd1,
      OPA_XB  = 3'd2,
      OPA_DBA = 3'd3,
      OPA_DCA = 3'd4,
      OPA_DCB = 3'd5
   } opa_type;

   // Operand B of the shared multiplier.
   typedef enum logic [3:0] {
      OPB_XB  = 4'd0,
      OPB_XC  = 4'd1,
      OPB_Y0  = 4'd2,
      OPB_Y1  = 4'd3,
      OPB_Y2  = 4'd4,
      OPB_DBA = 4'd5,
      OPB_DCA = 4'd6,
      OPB_DCB = 4'd7,
      OPB_SBA = 4'd8,
      OPB_SCA = 4'd9,
      OPB_SCB = 4'd10
   } opb_type;

   typedef enum logic [2:0] {
      DST_T   = 3'd0,
      DST_DET = 3'd1,
      DST_N0  = 3'd2,
      DST_N1  = 3'd3,
      DST_N2  = 3'd4
   } dst_type;

   typedef enum logic [1:0] {
      ACC_SET = 2'd0,
      ACC_ADD = 2'd1,
      ACC_SUB = 2'd2,
      ACC_NEG = 2'd3
   } acc_type;

   typedef struct packed {
      opa_type a;
      opb_type b;
      dst_type dst;
      acc_type acc;
   } uop_type;

   // Micro-program for the determinant and the three numerators.
   function automatic uop_type uop_rom(input logic [PC_W-1:0] idx);
      uop_type u;
      case (idx)
         5'd0:  u = '{OPA_DBA, OPB_DCA, DST_T,   ACC_SET};
         5'd1:  u = '{OPA_T,   OPB_DCB, DST_DET, ACC_SET};
         5'd2:  u = '{OPA_XB,  OPB_XC,  DST_T,   ACC_SET};
         5'd3:  u = '{OPA_T,   OPB_DCB, DST_T,   ACC_SET};
         5'd4:  u = '{OPA_T,   OPB_Y0,  DST_N0,  ACC_SET};
         5'd5:  u = '{OPA_XA,  OPB_XC,  DST_T,   ACC_SET};
         5'd6:  u = '{OPA_T,   OPB_DCA, DST_T,   ACC_SET};
         5'd7:  u = '{OPA_T,   OPB_Y1,  DST_N0,  ACC_SUB};
         5'd8:  u = '{OPA_XA,  OPB_XB,  DST_T,   ACC_SET};
         5'd9:  u = '{OPA_T,   OPB_DBA, DST_T,   ACC_SET};
         5'd10: u = '{OPA_T,   OPB_Y2,  DST_N0,  ACC_ADD};
         5'd11: u = '{OPA_DCB, OPB_SCB, DST_T,   ACC_SET};
         5'd12: u = '{OPA_T,   OPB_Y0,  DST_N1,  ACC_NEG};
         5'd13: u = '{OPA_DCA, OPB_SCA, DST_T,   ACC_SET};
         5'd14: u = '{OPA_T,   OPB_Y1,  DST_N1,  ACC_ADD};
         5'd15: u = '{OPA_DBA, OPB_SBA, DST_T,   ACC_SET};
         5'd16: u = '{OPA_T,   OPB_Y2,  DST_N1,  ACC_SUB};
         5'd17: u = '{OPA_DCB, OPB_Y0,  DST_N2,  ACC_SET};
         5'd18: u = '{OPA_DCA, OPB_Y1,  DST_N2,  ACC_SUB};
         5'd19: u = '{OPA_DBA, OPB_Y2,  DST_N2,  ACC_ADD};
         default: u = '{OPA_T, OPB_Y0, DST_T, ACC_SET};
      endcase
      return u;
   endfunction

endpackage

// File: design/quadratic_fit_three_points.sv
`timescale 1ns / 1ps

// Channel  | Direction | Ports                 | Contents
// req      | in        | req_tvalid/tready     | tdata: point_x, point_y
// rsp      | out       | rsp_tvalid/tready     | tdata: coef_index, coef_value; tuser: singular;
//          |           |                       | tlast: last
//
// The first two requests of a run are only stored. The third request starts a solve: twenty
// micro-operations of multiply and accumulate on the one shared multiplier, each in a multiply
// state and then an accumulate state, then for each coefficient a load, a restoring division
// of 88, 96 or 104 steps, a rounding step and an emit.
// A zero coefficient or a singular run skips the division and the rounding for it.
// Reset is synchronous and active high; it empties the run and the output register.
// A stalled result holds the sequencer in its emit step; req_tready is low during a solve.
module quadratic_fit_three_points (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [14:0] point_x, [30:15] point_y, [31] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [1:0] coef_index, [65:2] coef_value, [71:66] zero
   output logic        rsp_tuser,   // [0] singular
   output logic        rsp_tlast
);
   import qf3_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_ACC  = 7'b0000100,
      ST_LOAD = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_RND  = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] count_ff, count_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [1:0] k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [X_W-1:0] x_ff [3];
   logic [Y_W-1:0] y_ff [3];
   logic signed [VAL_W-1:0] prod_ff, prod_in;
   logic signed [T_W-1:0] t_ff, t_in;
   logic signed [VAL_W-1:0] det_ff, det_in;
   logic signed [VAL_W-1:0] num_ff [3];
   logic signed [VAL_W-1:0] num_in [3];
   logic [DMAG_W-1:0] d_ff, d_in;
   logic [VAL_W-1:0] m_ff, m_in, q_ff, q_in;
   logic [REM_W-1:0] r_ff, r_in;
   logic over_ff, over_in, neg_ff, neg_in, zero_ff, zero_in;
   logic [1:0] rsp_index_ff, rsp_index_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic rsp_singular_ff, rsp_singular_in, rsp_last_ff, rsp_last_in;

   logic req_take;
   logic slot_free;
   uop_type uop;
   logic signed [DIFF_W-1:0] dba, dca, dcb;
   logic [DIFF_W-1:0] sba, sca, scb;
   logic signed [T_W-1:0] opa_val;
   logic signed [OPB_W-1:0] opb_val;
   logic signed [T_W+OPB_W-1:0] product;
   logic signed [VAL_W-1:0] acc_cur, acc_new, num_sel;
   logic [VAL_W-1:0] det_abs, num_abs, limit, q_sat;
   logic [REM_W-1:0] rem_shift;
   logic rem_ge;
   logic [REM_W:0] rem_twice;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Differences and sums of the abscissae feed the multiplier.
   assign dba = DIFF_W'({2'b00, x_ff[1]}) - DIFF_W'({2'b00, x_ff[0]});
   assign dca = DIFF_W'({2'b00, x_ff[2]}) - DIFF_W'({2'b00, x_ff[0]});
   assign dcb = DIFF_W'({2'b00, x_ff[2]}) - DIFF_W'({2'b00, x_ff[1]});
   assign sba = DIFF_W'({2'b00, x_ff[1]}) + DIFF_W'({2'b00, x_ff[0]});
   assign sca = DIFF_W'({2'b00, x_ff[2]}) + DIFF_W'({2'b00, x_ff[0]});
   assign scb = DIFF_W'({2'b00, x_ff[2]}) + DIFF_W'({2'b00, x_ff[1]});

   assign uop = uop_rom(pc_ff);

   always_comb begin
      case (uop.a)
         OPA_T:   opa_val = t_ff;
         OPA_XA:  opa_val = T_W'({1'b0, x_ff[0]});
         OPA_XB:  opa_val = T_W'({1'b0, x_ff[1]});
         OPA_DBA: opa_val = T_W'(dba);
         OPA_DCA: opa_val = T_W'(dca);
         OPA_DCB: opa_val = T_W'(dcb);
         default: opa_val = t_ff;
      endcase
      case (uop.b)
         OPB_XB:  opb_val = OPB_W'({1'b0, x_ff[1]});
         OPB_XC:  opb_val = OPB_W'({1'b0, x_ff[2]});
         OPB_Y0:  opb_val = OPB_W'({1'b0, y_ff[0]});
         OPB_Y1:  opb_val = OPB_W'({1'b0, y_ff[1]});
         OPB_Y2:  opb_val = OPB_W'({1'b0, y_ff[2]});
         OPB_DBA: opb_val = OPB_W'(dba);
         OPB_DCA: opb_val = OPB_W'(dca);
         OPB_DCB: opb_val = OPB_W'(dcb);
         OPB_SBA: opb_val = OPB_W'({1'b0, sba});
         OPB_SCA: opb_val = OPB_W'({1'b0, sca});
         OPB_SCB: opb_val = OPB_W'({1'b0, scb});
         default: opb_val = '0;
      endcase
   end

   assign product = opa_val * opb_val;

   // Accumulation onto the numerator that the micro-operation names.
   always_comb begin
      case (uop.dst)
         DST_N0:  acc_cur = num_ff[0];
         DST_N1:  acc_cur = num_ff[1];
         DST_N2:  acc_cur = num_ff[2];
         default: acc_cur = num_ff[0];
      endcase
      case (uop.acc)
         ACC_SET: acc_new = prod_ff;
         ACC_ADD: acc_new = acc_cur + prod_ff;
         ACC_SUB: acc_new = acc_cur - prod_ff;
         ACC_NEG: acc_new = -prod_ff;
         default: acc_new = prod_ff;
      endcase
   end

   assign num_sel = num_ff[k_ff];
   assign det_abs = det_ff[VAL_W-1] ? VAL_W'(-det_ff) : VAL_W'(det_ff);
   assign num_abs = num_sel[VAL_W-1] ? VAL_W'(-num_sel) : VAL_W'(num_sel);

   // One restoring division step: bring down the next numerator bit.
   assign rem_shift = {r_ff[REM_W-2:0], m_ff[VAL_W-1]};
   assign rem_ge    = rem_shift >= REM_W'(d_ff);
   assign rem_twice = {r_ff, 1'b0};

   assign limit = neg_ff ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
   assign q_sat = (over_ff || (q_ff > limit)) ? limit : q_ff;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      pc_in           = pc_ff;
      k_in            = k_ff;
      cnt_in          = cnt_ff;
      prod_in         = prod_ff;
      t_in            = t_ff;
      det_in          = det_ff;
      num_in          = num_ff;
      d_in            = d_ff;
      m_in            = m_ff;
      q_in            = q_ff;
      r_in            = r_ff;
      over_in         = over_ff;
      neg_in          = neg_ff;
      zero_in         = zero_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_singular_in = rsp_singular_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (count_ff == 2'd2) begin
                  count_in = 2'd0;
                  pc_in    = '0;
                  state_in = ST_MUL;
               end else begin
                  count_in = count_ff + 2'd1;
               end
            end
         end
         ST_MUL: begin
            prod_in  = product[VAL_W-1:0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            case (uop.dst)
               DST_T:   t_in = prod_ff[T_W-1:0];
               DST_DET: det_in = prod_ff;
               DST_N0:  num_in[0] = acc_new;
               DST_N1:  num_in[1] = acc_new;
               DST_N2:  num_in[2] = acc_new;
               default: t_in = prod_ff[T_W-1:0];
            endcase
            if (pc_ff == PC_W'(NUM_UOPS - 1)) begin
               k_in     = 2'd0;
               state_in = ST_LOAD;
            end else begin
               pc_in    = pc_ff + PC_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_LOAD: begin
            d_in    = det_abs[DMAG_W-1:0];
            m_in    = num_abs;
            neg_in  = num_sel[VAL_W-1] ^ det_ff[VAL_W-1];
            zero_in = (det_ff == '0) || (num_sel == '0);
            q_in    = '0;
            r_in    = '0;
            over_in = 1'b0;
            cnt_in  = CNT_W'(VAL_W + FRAC_BASE) + CNT_W'({k_ff, 3'b000});
            state_in = ((det_ff == '0) || (num_sel == '0)) ? ST_EMIT : ST_DIV;
         end
         ST_DIV: begin
            r_in    = rem_ge ? (rem_shift - REM_W'(d_ff)) : rem_shift;
            q_in    = {q_ff[VAL_W-2:0], rem_ge};
            over_in = over_ff | q_ff[VAL_W-1];
            m_in    = {m_ff[VAL_W-2:0], 1'b0};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            if (!over_ff && (rem_twice >= (REM_W+1)'(d_ff))) begin
               if (&q_ff) begin
                  over_in = 1'b1;
               end else begin
                  q_in = q_ff + VAL_W'(1);
               end
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_index_in    = k_ff;
               rsp_value_in    = zero_ff ? '0 : (neg_ff ? VAL_W'(-q_sat) : q_sat);
               rsp_singular_in = (d_ff == '0);
               rsp_last_in     = (k_ff == 2'd2);
               if (k_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pc_ff        <= '0;
         k_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pc_ff        <= pc_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Point store: written at the run position of each accepted request.
   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff[count_ff] <= req_tdata[14:0];
         y_ff[count_ff] <= req_tdata[30:15];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff         <= prod_in;
      t_ff            <= t_in;
      det_ff          <= det_in;
      num_ff          <= num_in;
      d_ff            <= d_in;
      m_ff            <= m_in;
      q_ff            <= q_in;
      r_ff            <= r_in;
      over_ff         <= over_in;
      neg_ff          <= neg_in;
      zero_ff         <= zero_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_singular_ff <= rsp_singular_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_value_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_singular_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The last mark travels with the quadratic coefficient only.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_index_ff == 2'd2)))
      else $error("last mark and coefficient index disagree");

   // A singular solve yields zero coefficients.
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_singular_ff) |-> (rsp_value_ff == '0))
      else $error("singular result carries a non-zero value");

   // The run position never reaches three.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("point count out of range");

   // A fresh solve begins at the first micro-operation.
   a_solve_start: assert property (@(posedge clock) disable iff (reset)
      (req_take && (count_ff == 2'd2)) |=> ((state_ff == ST_MUL) && (pc_ff == '0)))
      else $error("solve did not start after the third point");

endmodule

// File: sim/quadratic_fit_three_points_tb.sv
`timescale 1ns / 1ps

module quadratic_fit_three_points_tb;

   localparam int unsigned IDLE_LIMIT = 20000;
   localparam int unsigned DRAIN_CYCLES = 400;

   typedef struct packed {
      logic [14:0] x;
      logic [15:0] y;
   } point_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [63:0] value;
      logic        singular;
      logic        last;
   } coef_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [14:0] point_x, [30:15] point_y, [31] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;    // [1:0] coef_index, [65:2] coef_value, [71:66] zero
   logic        rsp_tuser;    // [0] singular
   logic        rsp_tlast;

   point_type pending_points[$];
   coef_type  expected_coefs[$];
   point_type run_points[3];
   int unsigned run_fill;
   int unsigned error_count;
   int unsigned idle_cycles;
   int unsigned burst_left;
   int unsigned gap_left;
   int unsigned stall_phase;
   bit          stimulus_done;
   bit          req_done;

   quadratic_fit_three_points dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Rounded, saturated quotient num * 2^shift / det, computed in wide signed
   // arithmetic. Numerators stay below about 2^80 and the shift is at most 40, so
   // 192 bits leave ample headroom.
   function automatic logic [63:0] scaled_coef(input logic signed [191:0] num,
                                               input logic signed [191:0] det,
                                               input int unsigned shift);
      logic        [191:0] mag_n;
      logic        [191:0] mag_d;
      logic        [191:0] quot;
      logic        [191:0] rem;
      logic                negative;
      negative = (num < 0) != (det < 0);
      mag_n = (num < 0) ? -num : num;
      mag_d = (det < 0) ? -det : det;
      mag_n = mag_n << shift;
      quot = mag_n / mag_d;
      rem  = mag_n % mag_d;
      // Ties round away from zero.
      if ((rem << 1) >= mag_d) quot = quot + 1;
      if (negative) begin
         if (quot > 192'h8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
         return -quot[63:0];
      end
      if (quot > 192'h7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
      return quot[63:0];
   endfunction

   // Fits the quadratic through the three points of a completed run and queues
   // the three coefficients that the block should send back.
   task automatic predict_fit(input point_type p0, input point_type p1,
                              input point_type p2);
      logic signed [191:0] a, b, c, y0, y1, y2, det;
      logic signed [191:0] num[3];
      coef_type coef;
      a = p0.x; b = p1.x; c = p2.x;
      y0 = p0.y; y1 = p1.y; y2 = p2.y;
      det = (b - a) * (c - a) * (c - b);
      num[0] = y0 * b * c * (c - b) - y1 * a * c * (c - a) + y2 * a * b * (b - a);
      num[1] = -(y0 * (c * c - b * b) - y1 * (c * c - a * a) + y2 * (b * b - a * a));
      num[2] = y0 * (c - b) - y1 * (c - a) + y2 * (b - a);
      for (int k = 0; k < 3; k++) begin
         coef.index    = 2'(k);
         coef.singular = (det == 0);
         coef.last     = (k == 2);
         if (det == 0 || num[k] == 0) coef.value = '0;
         else coef.value = scaled_coef(num[k], det, 24 + 8 * k);
         expected_coefs.push_back(coef);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   task automatic add_run(input logic [14:0] x0, input logic [15:0] y0,
                          input logic [14:0] x1, input logic [15:0] y1,
                          input logic [14:0] x2, input logic [15:0] y2);
      pending_points.push_back('{x0, y0});
      pending_points.push_back('{x1, y1});
      pending_points.push_back('{x2, y2});
   endtask

   function automatic logic [14:0] random_x();
      case ($urandom_range(0, 9))
         0:       return 15'($urandom_range(0, 32767));   // past the nominal range
         1:       return 15'($urandom_range(0, 3));
         2:       return 15'($urandom_range(25500, 25600));
         default: return 15'($urandom_range(0, 25600));
      endcase
   endfunction

   function automatic logic [15:0] random_y();
      case ($urandom_range(0, 5))
         0:       return 16'hFFFF;
         1:       return 16'($urandom_range(0, 3));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Stimulus. Directed runs first: extremes, both singular forms, a sharp
   // curvature over unit spacing and all-zero samples. The random runs follow, mostly with distinct
   // abscissae and now and then with a repeated one.
   initial begin
      logic [14:0] xa, xb, xc;
      add_run(15'd0, 16'd0, 15'd12800, 16'd0, 15'd25600, 16'd0);
      add_run(15'd0, 16'hFFFF, 15'd12800, 16'd0, 15'd25600, 16'hFFFF);
      add_run(15'd0, 16'd0, 15'd1, 16'hFFFF, 15'd2, 16'd0);
      add_run(15'd0, 16'hFFFF, 15'd1, 16'd0, 15'd2, 16'hFFFF);
      add_run(15'h7FFF, 16'hFFFF, 15'h7FFE, 16'd0, 15'd0, 16'd1);
      add_run(15'd100, 16'd5, 15'd100, 16'd9, 15'd300, 16'd7);
      add_run(15'd7, 16'd7, 15'd7, 16'd7, 15'd7, 16'd7);
      add_run(15'd256, 16'd100, 15'd512, 16'd200, 15'd768, 16'd300);
      for (int n = 0; n < 82; n++) begin
         xa = random_x();
         xb = random_x();
         xc = random_x();
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1)) xb = xa;
            else xc = xb;
         end
         add_run(xa, random_y(), xb, random_y(), xc, random_y());
      end
   end

   // Driver: bursts of random length separated by random gaps. An offered request
   // is held until the edge at which it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_done) begin
         // The previous request was taken, or none was offered.
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_points.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, pending_points[0].y, pending_points[0].x};
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 8);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern: stretches of full speed, then random stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_phase <= (stall_phase + 1) % 64;
         if (stall_phase < 20) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 2) != 0);
      end
   end

   // Monitor: requests feed the predictor, results are checked in order.
   always @(posedge clock) begin
      coef_type want;
      req_done <= req_tvalid && req_tready;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (req_tvalid && req_tready) begin
            run_points[run_fill] = pending_points.pop_front();
            if (run_fill == 2) begin
               predict_fit(run_points[0], run_points[1], run_points[2]);
               run_fill = 0;
            end else begin
               run_fill = run_fill + 1;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_coefs.size() == 0) begin
               $display("%0t: coefficient %h received with none expected", $time,
                        rsp_tdata[65:2]);
               error_count++;
            end else begin
               want = expected_coefs.pop_front();
               if (rsp_tdata[1:0] != want.index)
                  report_mismatch("coef_index", 64'(rsp_tdata[1:0]), 64'(want.index));
               if (rsp_tdata[65:2] != want.value)
                  report_mismatch("coef_value", rsp_tdata[65:2], want.value);
               if (rsp_tuser != want.singular)
                  report_mismatch("singular", 64'(rsp_tuser), 64'(want.singular));
               if (rsp_tlast != want.last)
                  report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
            end
         end
      end
   end

   // Reset, then wait for the stimulus to drain, with a watchdog on progress.
   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      reset = 1'b1;
      run_fill = 0;
      error_count = 0;
      idle_cycles = 0;
      burst_left = 0;
      gap_left = 0;
      stall_phase = 0;
      stimulus_done = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (!stimulus_done) begin
         @(posedge clock);
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
         if (pending_points.size() == 0 && expected_coefs.size() == 0)
            stimulus_done = 1'b1;
      end
      // Let any stray result show itself before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_coefs.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/qf3_pkg.sv
design/quadratic_fit_three_points.sv
sim/quadratic_fit_three_points_tb.sv
